>>> hw/rtl/ctc_greedy_token_decoder_macros.svh
// Assertion macros shared by the CTC greedy token decoder RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef CTC_GREEDY_TOKEN_DECODER_MACROS_SVH
`define CTC_GREEDY_TOKEN_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication check
`define CTCGD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication check
`define CTCGD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CTCGD_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CTCGD_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> hw/rtl/ctcgd_pkg.sv
// Shared types and constants for the CTC greedy token decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ctcgd_pkg;

   // Field widths fixed by the stream format
   localparam int TOKEN_W    = 13;
   localparam int SCORE_W    = 16;
   localparam int THRESH_W   = 16;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - TOKEN_W - SCORE_W;

   // Parameter defaults
   localparam int NUM_CLASSES_DEF = 8192;
   localparam int PROB_BITS_DEF   = 16;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'h8000;
   localparam logic [TOKEN_W-1:0]  BLANK_CLASS  = '0;

   // Item kinds carried on tuser
   localparam logic MODE_ELEMENT = 1'b0;
   localparam logic MODE_CLEAR   = 1'b1;

   // Control part of one held input item
   typedef struct packed {
      logic clear;   // sequence clear, no probability
      logic last;    // final element of the frame
   } ctl_type;

endpackage

>>> hw/rtl/ctcgd_in_reg.sv
// Input register of the CTC greedy token decoder.
// Holds one accepted item until the core consumes it; uses ctcgd_pkg.
`timescale 1ns / 1ps

module ctcgd_in_reg #(
   parameter int PROB_BITS = ctcgd_pkg::PROB_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     req_tuser,
   input  logic                     req_tlast,
   input  logic [PROB_BITS-1:0]     req_prob,
   input  logic                     advance,
   output logic                     item_valid,
   output ctcgd_pkg::ctl_type       item_ctl,
   output logic [PROB_BITS-1:0]     item_prob
);
   import ctcgd_pkg::*;

   logic                 valid_ff, valid_in;
   ctl_type              ctl_ff;
   logic [PROB_BITS-1:0] prob_ff;
   logic                 take;

   // Free when empty or when the held item moves on this cycle
   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (take) begin
         ctl_ff.clear <= (req_tuser == MODE_CLEAR);
         ctl_ff.last  <= req_tlast;
         prob_ff      <= req_prob;
      end
   end

   assign item_valid = valid_ff;
   assign item_ctl   = ctl_ff;
   assign item_prob  = prob_ff;

endmodule

>>> hw/rtl/ctcgd_frame_max.sv
// Running maximum over one frame of class probabilities.
// Gives the frame's leading class and score for the held item; uses ctcgd_pkg.
`timescale 1ns / 1ps

module ctcgd_frame_max #(
   parameter int NUM_CLASSES = ctcgd_pkg::NUM_CLASSES_DEF,
   parameter int PROB_BITS   = ctcgd_pkg::PROB_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  ctcgd_pkg::ctl_type            item_ctl,
   input  logic [PROB_BITS-1:0]          item_prob,
   output logic [ctcgd_pkg::TOKEN_W-1:0] cand_class,
   output logic [PROB_BITS-1:0]          cand_prob
);
   import ctcgd_pkg::*;

   localparam int POS_W = $clog2(NUM_CLASSES + 1);

   logic [PROB_BITS-1:0] best_prob_ff, best_prob_in;
   logic [TOKEN_W-1:0]   best_class_ff, best_class_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic                 in_range;
   logic                 lead;

   // Only positions below the class count compete; first max wins ties
   assign in_range = pos_ff < POS_W'(NUM_CLASSES);
   assign lead     = in_range && ((pos_ff == '0) || (item_prob > best_prob_ff));

   // Leader including the held element
   assign cand_prob  = lead ? item_prob : best_prob_ff;
   assign cand_class = lead ? TOKEN_W'(pos_ff) : best_class_ff;

   always_comb begin
      best_prob_in  = best_prob_ff;
      best_class_in = best_class_ff;
      pos_in        = pos_ff;
      if (advance && !item_ctl.clear) begin
         if (item_ctl.last) begin
            best_prob_in  = '0;
            best_class_in = '0;
            pos_in        = '0;
         end else begin
            best_prob_in  = cand_prob;
            best_class_in = cand_class;
            if (in_range) begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_prob_ff  <= '0;
         best_class_ff <= '0;
         pos_ff        <= '0;
      end else begin
         best_prob_ff  <= best_prob_in;
         best_class_ff <= best_class_in;
         pos_ff        <= pos_in;
      end
   end

endmodule

>>> hw/rtl/ctcgd_emit.sv
// Blank/repeat collapse, threshold test and result register.
// Holds the last emitted token and the threshold register; uses ctcgd_pkg.
`timescale 1ns / 1ps

module ctcgd_emit #(
   parameter int PROB_BITS = ctcgd_pkg::PROB_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [ctcgd_pkg::THRESH_W-1:0]   csr_wr_data,
   input  logic                             advance,
   input  ctcgd_pkg::ctl_type               item_ctl,
   input  logic [ctcgd_pkg::TOKEN_W-1:0]    cand_class,
   input  logic [PROB_BITS-1:0]             cand_prob,
   output logic                             out_free,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ctcgd_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ctcgd_pkg::*;

   localparam int CMP_W = (PROB_BITS > THRESH_W) ? PROB_BITS : THRESH_W;

   logic [THRESH_W-1:0] thresh_ff;
   logic [TOKEN_W-1:0]  prev_token_ff, prev_token_in;
   logic                prev_valid_ff, prev_valid_in;
   logic                out_valid_ff, out_valid_in;
   logic [TOKEN_W-1:0]  token_ff;
   logic [SCORE_W-1:0]  score_ff;
   logic                not_blank, is_new, confident, fire;

   // Threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   // Frame-end decision
   assign not_blank = cand_class != BLANK_CLASS;
   assign is_new    = !prev_valid_ff || (cand_class != prev_token_ff);
   assign confident = CMP_W'(cand_prob) > CMP_W'(thresh_ff);
   assign fire      = advance && !item_ctl.clear && item_ctl.last
                      && not_blank && is_new && confident;

   // Last emitted token, forgotten on a clear
   always_comb begin
      prev_token_in = prev_token_ff;
      prev_valid_in = prev_valid_ff;
      if (advance && item_ctl.clear) begin
         prev_token_in = '0;
         prev_valid_in = 1'b0;
      end else if (fire) begin
         prev_token_in = cand_class;
         prev_valid_in = 1'b1;
      end
   end

   // Result register loads when empty or being taken
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = fire;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_token_ff <= '0;
         prev_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         prev_token_ff <= prev_token_in;
         prev_valid_ff <= prev_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         token_ff <= cand_class;
         score_ff <= SCORE_W'(cand_prob);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, score_ff, token_ff};

endmodule

>>> hw/rtl/ctc_greedy_token_decoder.sv
// CTC greedy token decoder: takes one class probability per cycle and emits
// at most one token per frame after blank and repeat collapse. An item is
// accepted every cycle unless the input stalls; a token is offered on the
// token stream once the frame's last element has passed the input register
// and then loaded the result register. The input stalls only while the
// result register holds a token that the sink has not taken. Ties keep the
// lowest class index; elements past NUM_CLASSES in a frame are ignored but
// their tlast still closes the frame.
// Depends on ctcgd_pkg, ctcgd_in_reg, ctcgd_frame_max, ctcgd_emit.
`timescale 1ns / 1ps
`include "ctc_greedy_token_decoder_macros.svh"

module ctc_greedy_token_decoder #(
   parameter int NUM_CLASSES = ctcgd_pkg::NUM_CLASSES_DEF,
   parameter int PROB_BITS   = ctcgd_pkg::PROB_BITS_DEF,
   localparam int REQ_DATA_W = ((PROB_BITS + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // Threshold register, Q0.16
   input  logic                             csr_wr_en,
   input  logic [ctcgd_pkg::THRESH_W-1:0]   csr_wr_data,
   // Probability stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [REQ_DATA_W-1:0]            req_tdata,   // prob, zero padded
   input  logic                             req_tuser,   // mode: 0 element, 1 clear
   input  logic                             req_tlast,   // frame_last
   // Token stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ctcgd_pkg::RSP_DATA_W-1:0] rsp_tdata    // token[12:0], token_score[28:13]
);
   import ctcgd_pkg::*;

   logic                 item_valid;
   ctl_type              item_ctl;
   logic [PROB_BITS-1:0] item_prob;
   logic [TOKEN_W-1:0]   cand_class;
   logic [PROB_BITS-1:0] cand_prob;
   logic                 out_free;
   logic                 advance;

   // Held item moves through the decision when the result slot is free
   assign advance = item_valid && out_free;

   ctcgd_in_reg #(
      .PROB_BITS (PROB_BITS)
   ) u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_prob   (req_tdata[PROB_BITS-1:0]),
      .advance    (advance),
      .item_valid (item_valid),
      .item_ctl   (item_ctl),
      .item_prob  (item_prob)
   );

   ctcgd_frame_max #(
      .NUM_CLASSES (NUM_CLASSES),
      .PROB_BITS   (PROB_BITS)
   ) u_frame_max (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item_ctl   (item_ctl),
      .item_prob  (item_prob),
      .cand_class (cand_class),
      .cand_prob  (cand_prob)
   );

   ctcgd_emit #(
      .PROB_BITS (PROB_BITS)
   ) u_emit (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .advance     (advance),
      .item_ctl    (item_ctl),
      .cand_class  (cand_class),
      .cand_prob   (cand_prob),
      .out_free    (out_free),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // Checks
   `CTCGD_ASSERT_IMP(a_no_blank_token, clock, reset, rsp_tvalid, rsp_tdata[TOKEN_W-1:0] != BLANK_CLASS, "blank class emitted")
   `CTCGD_ASSERT_IMP(a_stall_only_on_full_output, clock, reset, !req_tready, rsp_tvalid && !rsp_tready, "input stalled without output backpressure")
   `CTCGD_ASSERT_NXT(a_clear_gives_no_token, clock, reset, advance && item_ctl.clear, !rsp_tvalid, "clear item produced a token")

endmodule
